// File: rtl/core/gbff_pkg.sv
// Shared types, constants and table functions of the Gaussian bilayer form factor unit.
package gbff_pkg;

   // Stage count of the exponent and rotation chain
   localparam int DEF_CORDIC_STAGES = 20;
   localparam int MAX_STAGES        = 32;

   // Field widths
   localparam int Q_W        = 24;
   localparam int SIG_W      = 16;
   localparam int LEN_W      = 24;
   localparam int INT_W      = 48;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // Range reduction: quotient bits of the angle modulo 2pi, and of x / ln2
   localparam int THETA_BITS = 13;
   localparam int K_BITS     = 6;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LAYER_THICKNESS = 3'd0,
      REG_CORE_SIGMA      = 3'd1,
      REG_CORE_LENGTH     = 3'd2,
      REG_OUTER_SIGMA     = 3'd3,
      REG_OUTER_LENGTH    = 3'd4
   } csr_index_type;

   // Fixed-point constants
   localparam logic [63:0] TWOPI_Q32  = 64'd26986075409;
   localparam logic [34:0] TWOPI35    = 35'd26986075409;
   localparam logic [34:0] PI35       = 35'd13493037704;
   localparam logic [34:0] HALFPI35   = 35'd6746518852;
   localparam logic [31:0] QPI_Q32    = 32'd3373259426;
   localparam logic [33:0] GAIN_Q30   = 34'd652032874;
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
   localparam logic [62:0] CLIP63     = 63'h7FFF_FFFF_FFFF_FFFF;

   // Elaboration-time long division
   function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ln(1/(1-2^-i)) in Q.32 from its series in Q.48
   function automatic logic [31:0] ln_entry(input int i);
      logic [63:0] acc;
      acc = '0;
      for (int n = 1; n <= 48; n++) begin
         if (i * n <= 48) begin
            acc = acc + const_div(64'd1 << (48 - i * n), 64'(n));
         end
      end
      return 32'((acc + 64'h8000) >> 16);
   endfunction

   // atan(2^-i) in Q.32 from its series in Q.48
   function automatic logic [31:0] atan_entry(input int i);
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] term;
      pos = '0;
      neg = '0;
      for (int n = 0; n < 24; n++) begin
         if (i * (2 * n + 1) <= 48) begin
            term = const_div(64'd1 << (48 - i * (2 * n + 1)), 64'(2 * n + 1));
            if (n % 2 == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
      end
      if (i == 0) begin
         return QPI_Q32;
      end
      return 32'((pos - neg + 64'h8000) >> 16);
   endfunction

   localparam logic [31:0] LN2_Q32     = ln_entry(1);
   localparam logic [62:0] GAUSS_LIMIT = 63'(64'(LN2_Q32) * 64'd33);

   // Range reduction stage data
   typedef struct packed {
      logic             valid;
      logic [1:0]       zero;
      logic [1:0][36:0] xr;
      logic [1:0][5:0]  k;
      logic [46:0]      ang;
   } red_type;

   // Exponent and rotation stage data
   typedef struct packed {
      logic             valid;
      logic             flip;
      logic [1:0]       zero;
      logic [1:0][5:0]  k;
      logic [1:0][31:0] r;
      logic [1:0][32:0] e;
      logic [33:0]      cx;
      logic [33:0]      cy;
      logic [34:0]      cz;
   } rot_type;

   // Result transaction
   typedef struct packed {
      logic [INT_W-1:0] intensity;
      logic             divergent;
      logic             saturated;
   } rsp_type;

endpackage

// File: rtl/core/gbff_front.sv
// Front pipeline: q*sigma and q*d products, Gaussian argument and overflow check.
module gbff_front import gbff_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [Q_W-1:0]   in_q,
   input  logic [SIG_W-1:0] layer_thickness,
   input  logic [SIG_W-1:0] core_sigma,
   input  logic [SIG_W-1:0] outer_sigma,
   output red_type          front_out
);

   logic             v0_ff, v1_ff, v2_ff, v3_ff;
   logic [Q_W-1:0]   q0_ff;
   logic [1:0][39:0] t1_ff, t1_in;
   logic [39:0]      qd1_ff, qd1_in;
   logic [1:0][39:0] hh2_ff, hh2_in, hl2_ff, hl2_in, ll2_ff, ll2_in;
   logic [46:0]      ang2_ff, ang3_ff;
   logic [1:0][62:0] x3_ff, x3_in;
   red_type          out_ff, out_in;
   logic [79:0]      sq;

   // Multiply q by both sigmas and by the thickness
   always_comb begin
      t1_in[0] = 40'(q0_ff) * 40'(core_sigma);
      t1_in[1] = 40'(q0_ff) * 40'(outer_sigma);
      qd1_in   = 40'(q0_ff) * 40'(layer_thickness);
   end

   // Square t in 20-bit halves
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         hh2_in[l] = 40'(t1_ff[l][39:20]) * 40'(t1_ff[l][39:20]);
         hl2_in[l] = 40'(t1_ff[l][39:20]) * 40'(t1_ff[l][19:0]);
         ll2_in[l] = 40'(t1_ff[l][19:0]) * 40'(t1_ff[l][19:0]);
      end
   end

   // Sum partial products, take t^2/2 in Q.32
   always_comb begin
      sq = '0;
      for (int l = 0; l < 2; l++) begin
         sq = {hh2_ff[l], 40'b0} + {19'b0, hl2_ff[l], 21'b0} + {40'b0, ll2_ff[l]};
         x3_in[l] = sq[79:17];
      end
   end

   // Flag arguments at or past 33*ln2 and start the reduction
   always_comb begin
      out_in.valid = v3_ff;
      out_in.ang   = ang3_ff;
      for (int l = 0; l < 2; l++) begin
         out_in.zero[l] = (x3_ff[l] >= GAUSS_LIMIT);
         out_in.xr[l]   = x3_ff[l][36:0];
         out_in.k[l]    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         out_ff <= '0;
      end else if (en) begin
         v0_ff   <= in_valid;
         q0_ff   <= in_q;
         v1_ff   <= v0_ff;
         t1_ff   <= t1_in;
         qd1_ff  <= qd1_in;
         v2_ff   <= v1_ff;
         hh2_ff  <= hh2_in;
         hl2_ff  <= hl2_in;
         ll2_ff  <= ll2_in;
         ang2_ff <= {qd1_ff, 7'b0};
         v3_ff   <= v2_ff;
         x3_ff   <= x3_in;
         ang3_ff <= ang2_ff;
         out_ff  <= out_in;
      end
   end

   assign front_out = out_ff;

endmodule

// File: rtl/core/gbff_reduce_cell.sv
// Reduction cell: one restoring step of angle mod 2pi and, in the first K_BITS cells, of the argument by ln2.
module gbff_reduce_cell import gbff_pkg::*; #(
   parameter int J = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  red_type cell_in,
   output red_type cell_out
);

   localparam int          TB      = THETA_BITS - 1 - J;
   localparam logic [46:0] T_STEP  = 47'(TWOPI_Q32 << TB);
   localparam bit          DO_K    = (J < K_BITS);
   localparam int          KB      = DO_K ? K_BITS - 1 - J : 0;
   localparam logic [36:0] K_STEP  = 37'(64'(LN2_Q32) << KB);

   red_type cell_ff, cell_in_nxt;

   // Subtract the shifted divisors where they fit
   always_comb begin
      cell_in_nxt = cell_in;
      if (cell_in.ang >= T_STEP) begin
         cell_in_nxt.ang = cell_in.ang - T_STEP;
      end
      if (DO_K) begin
         for (int l = 0; l < 2; l++) begin
            if (cell_in.xr[l] >= K_STEP) begin
               cell_in_nxt.xr[l]    = cell_in.xr[l] - K_STEP;
               cell_in_nxt.k[l][KB] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (en) begin
         cell_ff <= cell_in_nxt;
      end
   end

   assign cell_out = cell_ff;

endmodule

// File: rtl/core/gbff_rot_cell.sv
// Chain cell: one exponent shift-and-subtract step per lane, applied up to twice, and one rotation step.
module gbff_rot_cell import gbff_pkg::*; #(
   parameter int I = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  rot_type cell_in,
   output rot_type cell_out
);

   localparam logic [31:0]        LN_STEP = ln_entry(I + 1);
   localparam logic signed [34:0] AT_STEP = 35'(atan_entry(I));

   rot_type cell_ff, cell_in_nxt;

   always_comb begin
      logic [31:0]        rr;
      logic [32:0]        ee;
      logic signed [33:0] cxv, cyv, xs, ys;
      logic signed [34:0] czv;
      cell_in_nxt = cell_in;
      // Exponent step, applied up to twice
      for (int l = 0; l < 2; l++) begin
         rr = cell_in.r[l];
         ee = cell_in.e[l];
         if (rr >= LN_STEP) begin
            rr = rr - LN_STEP;
            ee = ee - (ee >> (I + 1));
         end
         if (rr >= LN_STEP) begin
            rr = rr - LN_STEP;
            ee = ee - (ee >> (I + 1));
         end
         cell_in_nxt.r[l] = rr;
         cell_in_nxt.e[l] = ee;
      end
      // Rotate toward zero residual angle
      cxv = cell_in.cx;
      cyv = cell_in.cy;
      czv = cell_in.cz;
      xs  = cxv >>> I;
      ys  = cyv >>> I;
      if (!czv[34]) begin
         cell_in_nxt.cx = cxv - ys;
         cell_in_nxt.cy = cyv + xs;
         cell_in_nxt.cz = czv - AT_STEP;
      end else begin
         cell_in_nxt.cx = cxv + ys;
         cell_in_nxt.cy = cyv - xs;
         cell_in_nxt.cz = czv + AT_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (en) begin
         cell_ff <= cell_in_nxt;
      end
   end

   assign cell_out = cell_ff;

endmodule

// File: rtl/core/gbff_back.sv
// Back pipeline: layer amplitudes, sum, square, 2pi scaling and saturation.
module gbff_back import gbff_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  rot_type                 cell_in,
   input  logic [SIG_W-1:0]        core_sigma,
   input  logic [SIG_W-1:0]        outer_sigma,
   input  logic signed [LEN_W-1:0] core_scatter_length,
   input  logic signed [LEN_W-1:0] outer_scatter_length,
   output logic                    out_valid,
   output rsp_type                 out_data
);

   logic [9:0]       valid_ff;
   // stage 0
   logic [1:0][32:0] g0_ff, g0_in;
   logic [1:0][39:0] m0_ff, m0_in;
   logic [1:0]       np0_ff, np0_in;
   logic             nc0_ff, nc0_in, div0_ff, div0_in;
   logic [32:0]      mcos0_ff, mcos0_in;
   // stage 1
   logic [1:0][40:0] ph1_ff, ph1_in;
   logic [1:0][64:0] pl1_ff, pl1_in;
   logic [1:0]       np1_ff;
   logic             nc1_ff, div1_ff;
   logic [32:0]      mcos1_ff;
   // stage 2
   logic [1:0][40:0] mg2_ff, mg2_in;
   logic [1:0]       np2_ff;
   logic             nc2_ff, div2_ff;
   logic [32:0]      mcos2_ff;
   // stage 3
   logic [41:0]      ph3_ff, ph3_in;
   logic [64:0]      pl3_ff, pl3_in;
   logic [40:0]      tc3_ff, tc4_ff;
   logic             ntc3_ff, nto3_ff, div3_ff;
   // stage 4
   logic [44:0]      to4_ff, to4_in;
   logic             ntc4_ff, nto4_ff, div4_ff;
   // stage 5
   logic [45:0]      ms5_ff, ms5_in;
   logic             div5_ff;
   // stage 6
   logic [63:0]      pll6_ff, pll6_in;
   logic [45:0]      phl6_ff, phl6_in;
   logic [27:0]      phh6_ff, phh6_in;
   logic             div6_ff;
   // stage 7
   logic [62:0]      sq7_ff, sq7_in;
   logic             div7_ff;
   // stage 8
   logic [65:0]      rh8_ff, rh8_in;
   logic [66:0]      rl8_ff, rl8_in;
   logic             div8_ff;
   // stage 9
   rsp_type          out_ff, out_in;

   // Signed amplitudes, Gaussian shift and cosine sign
   always_comb begin
      logic signed [40:0] pc, po;
      logic signed [42:0] nsum;
      logic signed [33:0] cxv, cfv;
      pc       = $signed({1'b0, core_sigma}) * core_scatter_length;
      po       = $signed({1'b0, outer_sigma}) * outer_scatter_length;
      nsum     = (43'(po) <<< 1) + 43'(pc);
      div0_in  = (nsum == 43'sd0);
      np0_in   = {po[40], pc[40]};
      m0_in[0] = pc[40] ? 40'(-pc) : 40'(pc);
      m0_in[1] = po[40] ? 40'(-po) : 40'(po);
      for (int l = 0; l < 2; l++) begin
         g0_in[l] = cell_in.zero[l] ? 33'd0 : (cell_in.e[l] >> cell_in.k[l]);
      end
      cxv      = cell_in.cx;
      cfv      = cell_in.flip ? -cxv : cxv;
      nc0_in   = cfv[33];
      mcos0_in = cfv[33] ? 33'(-cfv) : 33'(cfv);
   end

   // Amplitude times Gaussian, partial products
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ph1_in[l] = 41'(m0_ff[l][39:32]) * 41'(g0_ff[l]);
         pl1_in[l] = 65'(m0_ff[l][31:0]) * 65'(g0_ff[l]);
      end
   end

   // Combine and floor to Q.20
   always_comb begin
      logic [72:0] prod;
      prod = '0;
      for (int l = 0; l < 2; l++) begin
         prod      = {ph1_ff[l], 32'b0} + 73'(pl1_ff[l]);
         mg2_in[l] = prod[72:32];
      end
   end

   // Outer amplitude times cosine, partial products
   always_comb begin
      ph3_in = 42'(mg2_ff[1][40:32]) * 42'(mcos2_ff);
      pl3_in = 65'(mg2_ff[1][31:0]) * 65'(mcos2_ff);
   end

   // Floor from Q.30, double for both outer layers
   always_comb begin
      logic [73:0] prod;
      prod   = {ph3_ff, 32'b0} + 74'(pl3_ff);
      to4_in = {prod[73:30], 1'b0};
   end

   // Signed sum of core and outer terms, take magnitude
   always_comb begin
      logic signed [46:0] st;
      st     = (ntc4_ff ? -$signed(47'(tc4_ff)) : $signed(47'(tc4_ff)))
             + (nto4_ff ? -$signed(47'(to4_ff)) : $signed(47'(to4_ff)));
      ms5_in = st[46] ? 46'(-st) : 46'(st);
   end

   // Square, partial products
   always_comb begin
      pll6_in = 64'(ms5_ff[31:0]) * 64'(ms5_ff[31:0]);
      phl6_in = 46'(ms5_ff[45:32]) * 46'(ms5_ff[31:0]);
      phh6_in = 28'(ms5_ff[45:32]) * 28'(ms5_ff[45:32]);
   end

   // Combine square, floor to Q.16, clip
   always_comb begin
      logic [91:0] sqf;
      sqf    = {phh6_ff, 64'b0} + {13'b0, phl6_ff, 33'b0} + 92'(pll6_ff);
      sq7_in = (sqf[91:24] > 68'(CLIP63)) ? CLIP63 : sqf[86:24];
   end

   // Scale by 2pi, partial products
   always_comb begin
      rh8_in = 66'(sq7_ff[62:32]) * 66'(TWOPI35);
      rl8_in = 67'(sq7_ff[31:0]) * 67'(TWOPI35);
   end

   // Floor, saturate at full scale
   always_comb begin
      logic [97:0] full;
      logic        sat;
      full             = {rh8_ff, 32'b0} + 98'(rl8_ff);
      sat              = |full[97:80];
      out_in.saturated = sat;
      out_in.intensity = sat ? {INT_W{1'b1}} : full[79:32];
      out_in.divergent = div8_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[8:0], cell_in.valid};
      end
   end

   // Advance payload with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         g0_ff    <= g0_in;
         m0_ff    <= m0_in;
         np0_ff   <= np0_in;
         nc0_ff   <= nc0_in;
         div0_ff  <= div0_in;
         mcos0_ff <= mcos0_in;
         ph1_ff   <= ph1_in;
         pl1_ff   <= pl1_in;
         np1_ff   <= np0_ff;
         nc1_ff   <= nc0_ff;
         div1_ff  <= div0_ff;
         mcos1_ff <= mcos0_ff;
         mg2_ff   <= mg2_in;
         np2_ff   <= np1_ff;
         nc2_ff   <= nc1_ff;
         div2_ff  <= div1_ff;
         mcos2_ff <= mcos1_ff;
         ph3_ff   <= ph3_in;
         pl3_ff   <= pl3_in;
         tc3_ff   <= mg2_ff[0];
         ntc3_ff  <= np2_ff[0];
         nto3_ff  <= np2_ff[1] ^ nc2_ff;
         div3_ff  <= div2_ff;
         to4_ff   <= to4_in;
         tc4_ff   <= tc3_ff;
         ntc4_ff  <= ntc3_ff;
         nto4_ff  <= nto3_ff;
         div4_ff  <= div3_ff;
         ms5_ff   <= ms5_in;
         div5_ff  <= div4_ff;
         pll6_ff  <= pll6_in;
         phl6_ff  <= phl6_in;
         phh6_ff  <= phh6_in;
         div6_ff  <= div5_ff;
         sq7_ff   <= sq7_in;
         div7_ff  <= div6_ff;
         rh8_ff   <= rh8_in;
         rl8_ff   <= rl8_in;
         div8_ff  <= div7_ff;
         out_ff   <= out_in;
      end
   end

   assign out_valid = valid_ff[9];
   assign out_data  = out_ff;

endmodule

// File: rtl/core/gaussian_bilayer_form_factor_unit.sv
// Throughput: one transaction per cycle while the skid buffer is empty;
// every stage of the cell chain holds one q value.
// Rate is set by the pipelined range reduction, exponent/rotation cell chain and split products.
// A one-entry skid buffer takes a response that waits, so requests keep flowing while it is captured.
// Synchronous active-high reset clears config, cell and valid registers and empties the pipeline.
module gaussian_bilayer_form_factor_unit import gbff_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [Q_W-1:0]        req_scatter_vector,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INT_W-1:0]      rsp_intensity,
   output logic                  rsp_divergent,
   output logic                  rsp_saturated,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int N = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

   logic [SIG_W-1:0] thick_ff, core_sigma_ff, outer_sigma_ff;
   logic [LEN_W-1:0] core_len_ff, outer_len_ff;
   logic             en;
   red_type          red_link [0:THETA_BITS];
   rot_type          rot_link [0:N];
   rot_type          fold_ff, fold_in;
   logic             m_valid;
   rsp_type          m_data;
   logic             skid_valid_ff, skid_valid_in;
   rsp_type          skid_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff       <= '0;
         core_sigma_ff  <= '0;
         core_len_ff    <= '0;
         outer_sigma_ff <= '0;
         outer_len_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LAYER_THICKNESS: thick_ff       <= csr_write_data[SIG_W-1:0];
            REG_CORE_SIGMA:      core_sigma_ff  <= csr_write_data[SIG_W-1:0];
            REG_CORE_LENGTH:     core_len_ff    <= csr_write_data[LEN_W-1:0];
            REG_OUTER_SIGMA:     outer_sigma_ff <= csr_write_data[SIG_W-1:0];
            REG_OUTER_LENGTH:    outer_len_ff   <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline advances while the skid buffer is empty
   assign en        = !skid_valid_ff;
   assign req_ready = en && !reset;

   gbff_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_valid && req_ready),
      .in_q            (req_scatter_vector),
      .layer_thickness (thick_ff),
      .core_sigma      (core_sigma_ff),
      .outer_sigma     (outer_sigma_ff),
      .front_out       (red_link[0])
   );

   for (genvar j = 0; j < THETA_BITS; j++) begin : g_reduce
      gbff_reduce_cell #(.J(j)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (red_link[j]),
         .cell_out (red_link[j + 1])
      );
   end

   // Fold the angle into [0, pi/2] and seed the rotation and exponent
   always_comb begin
      logic [34:0] a, a1, z;
      logic        flip;
      a            = red_link[THETA_BITS].ang[34:0];
      a1           = (a > PI35) ? TWOPI35 - a : a;
      flip         = (a1 > HALFPI35);
      z            = flip ? PI35 - a1 : a1;
      fold_in.valid = red_link[THETA_BITS].valid;
      fold_in.flip  = flip;
      fold_in.zero  = red_link[THETA_BITS].zero;
      fold_in.k     = red_link[THETA_BITS].k;
      for (int l = 0; l < 2; l++) begin
         fold_in.r[l] = red_link[THETA_BITS].xr[l][31:0];
         fold_in.e[l] = ONE_Q32;
      end
      fold_in.cx = GAIN_Q30;
      fold_in.cy = '0;
      fold_in.cz = z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= '0;
      end else if (en) begin
         fold_ff <= fold_in;
      end
   end

   assign rot_link[0] = fold_ff;

   for (genvar i = 0; i < N; i++) begin : g_rot
      gbff_rot_cell #(.I(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (rot_link[i]),
         .cell_out (rot_link[i + 1])
      );
   end

   gbff_back u_back (
      .clock                (clock),
      .reset                (reset),
      .en                   (en),
      .cell_in              (rot_link[N]),
      .core_sigma           (core_sigma_ff),
      .outer_sigma          (outer_sigma_ff),
      .core_scatter_length  (core_len_ff),
      .outer_scatter_length (outer_len_ff),
      .out_valid            (m_valid),
      .out_data             (m_data)
   );

   // Hold a response that was not taken while the pipeline moved on
   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_in = 1'b0;
         end
      end else if (m_valid && !rsp_ready) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_ff <= m_data;
      end
   end

   assign rsp_valid     = skid_valid_ff || m_valid;
   assign rsp_intensity = skid_valid_ff ? skid_ff.intensity : m_data.intensity;
   assign rsp_divergent = skid_valid_ff ? skid_ff.divergent : m_data.divergent;
   assign rsp_saturated = skid_valid_ff ? skid_ff.saturated : m_data.saturated;

endmodule

// File: test/gaussian_bilayer_form_factor_unit_tb.sv
// Testbench for the Gaussian bilayer form factor unit: random and directed q sweeps.
`timescale 1ns / 1ps

module gaussian_bilayer_form_factor_unit_tb;
   import gbff_pkg::*;

   localparam int STAGES      = (DEF_CORDIC_STAGES < MAX_STAGES) ? DEF_CORDIC_STAGES : MAX_STAGES;
   localparam int DRAIN_WAIT  = 29 + DEF_CORDIC_STAGES + 20;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint unsigned CLIP_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned FULL_VAL = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned TWOPI_V  = 64'd26986075409;
   localparam longint unsigned PI_V     = 64'd13493037704;
   localparam longint          HALFPI_V = 64'sd6746518852;
   localparam longint          GAIN_V   = 64'sd652032874;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [Q_W-1:0]        req_scatter_vector;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [INT_W-1:0]      rsp_intensity;
   logic                  rsp_divergent;
   logic                  rsp_saturated;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   gaussian_bilayer_form_factor_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_scatter_vector(req_scatter_vector),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_intensity(rsp_intensity),
      .rsp_divergent(rsp_divergent), .rsp_saturated(rsp_saturated),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Mirror of the register file
   logic [15:0]        thick_cfg;
   logic [15:0]        core_sig_cfg;
   logic signed [23:0] core_len_cfg;
   logic [15:0]        outer_sig_cfg;
   logic signed [23:0] outer_len_cfg;

   longint unsigned ln_tab [0:32];
   longint          atan_tab [0:32];

   logic [Q_W-1:0] q_pending [$];
   rsp_type        form_expected [$];
   int             idle_pct;
   int             stall_pct;
   int             error_count;
   int             cycle_count;
   bit             q_taken;

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // floor(a*b / 2^s), clipped at 2^63-1
   function automatic longint unsigned mul_floor(longint unsigned a, longint unsigned b, int s);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      return (p > {64'd0, CLIP_VAL}) ? CLIP_VAL : p[63:0];
   endfunction

   function automatic longint unsigned ln_series(int i);
      longint unsigned acc;
      acc = 0;
      for (int n = 1; i * n <= 48; n++) acc += (64'd1 << (48 - i * n)) / n;
      return (acc + 64'h8000) >> 16;
   endfunction

   function automatic longint atan_series(int i);
      longint unsigned pos, neg, t;
      pos = 0;
      neg = 0;
      if (i == 0) return 64'sd3373259426;
      for (int n = 0; i * (2 * n + 1) <= 48; n++) begin
         t = (64'd1 << (48 - i * (2 * n + 1))) / (2 * n + 1);
         if (n % 2 == 1) neg += t;
         else pos += t;
      end
      return longint'((pos - neg + 64'h8000) >> 16);
   endfunction

   // exp(-(q*s)^2/2) in Q.32
   function automatic longint unsigned gaussian_q32(longint unsigned q, longint unsigned s);
      longint unsigned t, x, k, r, e;
      t = q * s;
      x = mul_floor(t, t, 17);
      k = x / ln_tab[1];
      e = 64'd1 << 32;
      if (k >= 33) return 0;
      r = x - k * ln_tab[1];
      for (int i = 1; i <= STAGES; i++) begin
         if (r >= ln_tab[i]) begin r -= ln_tab[i]; e -= e >> i; end
         if (r >= ln_tab[i]) begin r -= ln_tab[i]; e -= e >> i; end
      end
      return e >> k;
   endfunction

   // cos(theta) in signed Q.30 by rotation
   function automatic longint cosine_q30(longint unsigned theta);
      longint unsigned a;
      longint z, x, y, xs, ys;
      bit flip;
      a = theta % TWOPI_V;
      x = GAIN_V;
      y = 0;
      flip = 0;
      if (a > PI_V) a = TWOPI_V - a;
      z = longint'(a);
      if (z > HALFPI_V) begin z = longint'(PI_V) - z; flip = 1; end
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin x -= ys; y += xs; z -= atan_tab[i]; end
         else begin x += ys; y -= xs; z += atan_tab[i]; end
      end
      return flip ? -x : x;
   endfunction

   function automatic rsp_type form_factor(logic [Q_W-1:0] q_in);
      longint unsigned q, gc, go, mc, mo, mcos, ms, sq, r;
      longint pc, po, c, tc, tv, s;
      rsp_type res;
      q = {40'd0, q_in};
      pc = longint'({48'd0, core_sig_cfg}) * longint'(core_len_cfg);
      po = longint'({48'd0, outer_sig_cfg}) * longint'(outer_len_cfg);
      gc = gaussian_q32(q, {48'd0, core_sig_cfg});
      go = gaussian_q32(q, {48'd0, outer_sig_cfg});
      c = cosine_q30((q * {48'd0, thick_cfg}) << 7);
      mc = (pc < 0) ? -pc : pc;
      mo = (po < 0) ? -po : po;
      mcos = (c < 0) ? -c : c;
      tc = longint'(mul_floor(mc, gc, 32));
      tv = longint'(mul_floor(mul_floor(mo, go, 32), mcos, 30)) * 2;
      if (pc < 0) tc = -tc;
      if ((po < 0) != (c < 0)) tv = -tv;
      s = tc + tv;
      ms = (s < 0) ? -s : s;
      sq = mul_floor(ms, ms, 24);
      r = mul_floor(sq, TWOPI_V, 32);
      res.saturated = (r > FULL_VAL);
      res.intensity = res.saturated ? FULL_VAL[47:0] : r[47:0];
      res.divergent = (2 * po + pc == 0);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Accept requests, check responses
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            form_expected.push_back(form_factor(req_scatter_vector));
            void'(q_pending.pop_front());
            q_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (form_expected.size() == 0) begin
               report_mismatch("unexpected transaction", 64'(rsp_intensity), 64'd0);
            end else begin
               want = form_expected.pop_front();
               if (rsp_intensity !== want.intensity)
                  report_mismatch("intensity", 64'(rsp_intensity), 64'(want.intensity));
               if (rsp_divergent !== want.divergent)
                  report_mismatch("divergent", 64'(rsp_divergent), 64'(want.divergent));
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 64'(rsp_saturated), 64'(want.saturated));
            end
         end
      end
   end

   // Drive requests and response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // Hold a transaction that is still waiting
         if (!(req_valid && !q_taken)) begin
            if (q_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_scatter_vector <= q_pending[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         q_taken = 0;
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("FAIL gaussian_bilayer_form_factor_unit");
         $finish;
      end
   end

   task automatic write_regs(logic [15:0] d, logic [15:0] sc, logic [23:0] bc,
                             logic [15:0] so, logic [23:0] bo);
      csr_index_type idx [5];
      logic [23:0] val [5];
      idx = '{REG_LAYER_THICKNESS, REG_CORE_SIGMA, REG_CORE_LENGTH, REG_OUTER_SIGMA,
              REG_OUTER_LENGTH};
      val = '{{8'd0, d}, {8'd0, sc}, bc, {8'd0, so}, bo};
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= val[i];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      thick_cfg = d;
      core_sig_cfg = sc;
      core_len_cfg = bc;
      outer_sig_cfg = so;
      outer_len_cfg = bo;
   endtask

   // Wait for all responses, then let the pipeline empty
   task automatic drain;
      while (q_pending.size() > 0 || form_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic queue_random_q(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: q_pending.push_back(24'($urandom_range(16777215)));
            1: q_pending.push_back(24'($urandom_range(65535)));
            default: q_pending.push_back(24'($urandom_range(4095)));
         endcase
      end
   endtask

   initial begin
      logic [Q_W-1:0] directed_q [12];
      for (int i = 0; i <= 32; i++) begin
         ln_tab[i] = (i == 0) ? 0 : ln_series(i);
         atan_tab[i] = atan_series(i);
      end
      thick_cfg = 0;
      core_sig_cfg = 0;
      core_len_cfg = 0;
      outer_sig_cfg = 0;
      outer_len_cfg = 0;
      error_count = 0;
      cycle_count = 0;
      q_taken = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_scatter_vector = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_LAYER_THICKNESS;
      csr_write_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: all zero, divergent everywhere
      q_pending.push_back(24'd0);
      q_pending.push_back(24'hFFFFFF);
      q_pending.push_back(24'h000100);
      drain();

      // Directed: moderate setting, extreme q values
      directed_q = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'h010000, 24'h004000,
                     24'h7FFFFF, 24'h000800, 24'h002000, 24'h100000, 24'h0000FF, 24'h555555};
      write_regs(16'h0A00, 16'h0180, 24'h001000, 16'h0100, 24'hFFF000);
      foreach (directed_q[i]) q_pending.push_back(directed_q[i]);
      drain();
      // Saturation: widest sigma with strongest lengths, mostly near q = 0 and one at the largest q
      write_regs(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 16'hFFFF, 24'h7FFFFF);
      q_pending.push_back(24'd0);
      q_pending.push_back(24'd1);
      q_pending.push_back(24'h000010);
      q_pending.push_back(24'hFFFFFF);
      drain();
      // Divergence with nonzero intensity: sc = so, bc = -2*bo
      write_regs(16'h1234, 16'h0200, 24'hFFE000, 16'h0200, 24'h001000);
      q_pending.push_back(24'd0);
      q_pending.push_back(24'h000400);
      q_pending.push_back(24'h003000);
      drain();
      // Zero sigmas: Gaussians exactly one, most negative lengths
      write_regs(16'h8000, 16'h0000, 24'h800000, 16'h0000, 24'h800000);
      q_pending.push_back(24'hFFFFFF);
      q_pending.push_back(24'h012345);
      drain();

      // Random phases over idle and stall patterns and register settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         if (ph % 3 == 0)
            write_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       24'($urandom_range(16777215)), 16'($urandom_range(65535)),
                       24'($urandom_range(16777215)));
         else
            write_regs(16'($urandom_range(8191)), 16'($urandom_range(1023)),
                       24'($urandom_range(16777215)), 16'($urandom_range(1023)),
                       24'($urandom_range(16777215)));
         queue_random_q(52);
         drain();
      end

      if (error_count == 0) begin
         $display("PASS gaussian_bilayer_form_factor_unit");
      end else begin
         $display("FAIL gaussian_bilayer_form_factor_unit");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/gbff_pkg.sv
rtl/core/gbff_front.sv
rtl/core/gbff_reduce_cell.sv
rtl/core/gbff_rot_cell.sv
rtl/core/gbff_back.sv
rtl/core/gaussian_bilayer_form_factor_unit.sv
test/gaussian_bilayer_form_factor_unit_tb.sv
